### sv/assert_macros.svh
// Assertion helpers used by the checker file.
// The enclosing scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ECS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ECS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define ECS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ecs_pkg.sv
// ----------------------------------------------------------------------------
// ecs_pkg
// Shared types and constants of the embedding cosine similarity unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecs_pkg;

    localparam int VOCAB_DEPTH_DEF = 4096;
    localparam int MAX_DIM_DEF     = 512;

    localparam int CFG_W   = 10;
    localparam int VAL_W   = 16;
    localparam int ROW_W   = 12;
    localparam int ID_W    = 13;
    localparam int SCORE_W = 32;
    localparam int MISS_W  = 16;
    localparam int ACC_W   = 48;
    localparam int SUM_W   = 48;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int NUM_W   = 39;

    localparam logic [CFG_W-1:0] DIM_RESET = 10'd300;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Clamp the Q18.30 accumulator into the 32-bit Q2.30 score range.
    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh0000_0000_7FFF_FFFF);
        lo = ACC_W'(-64'sh0000_0000_8000_0000);
        if (a > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (a < lo)
        begin
            return 32'sh8000_0000;
        end
        return a[SCORE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/embedding_cosine_similarity_unit.sv
// ----------------------------------------------------------------------------
// embedding_cosine_similarity_unit
// Embedding table with row normalization and cosine-similarity queries.
// ----------------------------------------------------------------------------
// Input (in_valid / in_stall): func 0 carries one raw Q4.12 component of the
//   row named by word_index; func 1 queries first_word and second_word
//   (-1 or out of range means unknown). Output (out_valid / out_stall): one
//   transaction per query and per completed row load; load_done tells them
//   apart. cfg_wr_en / cfg_wr_data set embedding_dim; write only while idle.
// Sequence: a load component that does not finish a row leaves the block
//   idle for the next one. Finishing a row: square root, then per component
//   read, divider start, 39 divider steps, write-back; a zero-norm row skips
//   the square root and divider. Query: one multiply-accumulate per
//   component fed by the dual-read table port; a miss goes straight to the
//   result stage. in_stall is high while an item is in progress.
// Reset: control clears, embedding_dim returns to 300, miss counter to 0;
//   the table holds garbage until rows are loaded.
// Stall: a result sits in the output register; the block keeps accepting,
//   and only holds when a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module embedding_cosine_similarity_unit #(
    parameter int VOCAB_DEPTH = ecs_pkg::VOCAB_DEPTH_DEF,
    parameter int MAX_DIM     = ecs_pkg::MAX_DIM_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ecs_pkg::CFG_W-1:0]           cfg_wr_data,
    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire logic                                func,
    input  wire logic [ecs_pkg::ROW_W-1:0]           word_index,
    input  wire logic signed [ecs_pkg::VAL_W-1:0]    element_value,
    input  wire logic signed [ecs_pkg::ID_W-1:0]     first_word,
    input  wire logic signed [ecs_pkg::ID_W-1:0]     second_word,
    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      logic signed [ecs_pkg::SCORE_W-1:0]  score,
    output      logic                                missing,
    output      logic                                zero_norm,
    output      logic                                load_done,
    output      logic [ecs_pkg::MISS_W-1:0]          miss_count
);

    localparam int CNT_W     = $clog2(MAX_DIM + 1);
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int TBL_DEPTH = VOCAB_DEPTH * MAX_DIM;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQRT   = 3'd1;
    localparam logic [2:0] ST_NRD    = 3'd2;
    localparam logic [2:0] ST_NDIV   = 3'd3;
    localparam logic [2:0] ST_NWAIT  = 3'd4;
    localparam logic [2:0] ST_QRUN   = 3'd5;
    localparam logic [2:0] ST_QDRAIN = 3'd6;
    localparam logic [2:0] ST_POST   = 3'd7;

    logic [2:0]                  state_reg;
    logic [ecs_pkg::CFG_W-1:0]   dim_reg;
    logic [ecs_pkg::SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [ecs_pkg::MISS_W-1:0]  miss_cnt_reg;
    logic [CNT_W-1:0]            j_reg;
    logic [CNT_W-1:0]            n_reg;
    logic [CNT_W-1:0]            qj_reg;
    logic                        rd_vld_reg;
    logic                        out_valid_reg;

    // Payload registers
    logic [ADDR_W-1:0]           row_base_reg;
    logic                        row_ok_reg;
    logic                        zn_reg;
    logic [ecs_pkg::ROOT_W-1:0]  norm_reg;
    logic                        neg_reg;
    logic [ADDR_W-1:0]           base_a_reg;
    logic [ADDR_W-1:0]           base_b_reg;
    logic signed [ecs_pkg::SCORE_W-1:0] post_score_reg;
    logic                        post_missing_reg;
    logic                        post_zn_reg;
    logic                        post_ld_reg;
    logic signed [ecs_pkg::SCORE_W-1:0] score_reg;
    logic                        missing_reg;
    logic                        zn_out_reg;
    logic                        ld_out_reg;
    logic [ecs_pkg::MISS_W-1:0]  miss_out_reg;

    // Memories
    logic signed [ecs_pkg::VAL_W-1:0] tbl_mem [TBL_DEPTH];
    logic signed [ecs_pkg::VAL_W-1:0] stg_mem [MAX_DIM];
    logic signed [ecs_pkg::VAL_W-1:0] tbl_rd_a_reg;
    logic signed [ecs_pkg::VAL_W-1:0] tbl_rd_b_reg;
    logic signed [ecs_pkg::VAL_W-1:0] stg_rd_reg;

    logic [CNT_W-1:0]            dim_eff;
    logic signed [31:0]          sq;
    logic [ecs_pkg::SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]            cnt_next;
    logic                        accept;
    logic                        load_cmpl;
    logic                        zn_now;
    logic                        query_miss;
    logic                        post_free;
    logic                        acc_done;
    logic                        norm_step;
    logic                        last_comp;
    logic                        tbl_we;
    logic [ADDR_W-1:0]           tbl_waddr;
    logic signed [ecs_pkg::VAL_W-1:0] tbl_wdata;
    logic [ADDR_W-1:0]           addr_a;
    logic [ADDR_W-1:0]           addr_b;
    logic [16:0]                 mag;
    logic                        div_start;
    logic [ecs_pkg::NUM_W-1:0]   div_num;
    logic [ecs_pkg::NUM_W-1:0]   quot;
    logic signed [ecs_pkg::VAL_W-1:0] unit_val;
    logic                        sqrt_start;
    logic [ecs_pkg::ROOT_W-1:0]  root;
    ecs_pkg::unit_stat_t         sqrt_stat;
    ecs_pkg::unit_stat_t         div_stat;
    logic                        mac_clear;
    logic                        mac_busy;
    logic signed [ecs_pkg::ACC_W-1:0] acc;

    // Effective dimension: 0 behaves as 1, above MAX_DIM clamps.
    always_comb
    begin
        if (dim_reg == '0)
        begin
            dim_eff = CNT_W'(1);
        end
        else if (32'(dim_reg) > 32'(MAX_DIM))
        begin
            dim_eff = CNT_W'(MAX_DIM);
        end
        else
        begin
            dim_eff = CNT_W'(dim_reg);
        end
    end

    assign accept     = in_valid && !in_stall;
    assign sq         = element_value * element_value;
    assign sum_next   = sum_reg + {16'b0, sq};
    assign cnt_next   = cnt_reg + CNT_W'(1);
    assign load_cmpl  = (cnt_next >= dim_eff);
    assign zn_now     = (sum_next == '0);
    assign query_miss = first_word[ecs_pkg::ID_W-1] || second_word[ecs_pkg::ID_W-1] ||
                        (32'(first_word[ecs_pkg::ID_W-2:0]) >= 32'(VOCAB_DEPTH)) ||
                        (32'(second_word[ecs_pkg::ID_W-2:0]) >= 32'(VOCAB_DEPTH));
    assign post_free  = !out_valid_reg || !out_stall;
    assign acc_done   = (state_reg == ST_QDRAIN) && !rd_vld_reg && !mac_busy;

    // One component finished: zero-norm rows skip the divider.
    assign norm_step  = ((state_reg == ST_NDIV) && zn_reg) ||
                        ((state_reg == ST_NWAIT) && div_stat.done);
    assign last_comp  = ((j_reg + CNT_W'(1)) == n_reg);

    assign sqrt_start = accept && (func == ecs_pkg::FUNC_LOAD) && load_cmpl && !zn_now;
    assign div_start  = (state_reg == ST_NDIV) && !zn_reg;
    assign mac_clear  = accept && (func == ecs_pkg::FUNC_QUERY);

    // Magnitude of the staged component, scaled numerator with round-half-up.
    assign mag     = stg_rd_reg[ecs_pkg::VAL_W-1] ? 17'(-(17'(stg_rd_reg)))
                                                   : 17'(stg_rd_reg);
    assign div_num = (ecs_pkg::NUM_W'(mag) << 23) + ecs_pkg::NUM_W'(norm_reg >> 1);

    // Saturate the quotient into Q1.15 with the saved sign.
    always_comb
    begin
        if (neg_reg)
        begin
            unit_val = (quot > ecs_pkg::NUM_W'(32768)) ? 16'sh8000 : -(quot[15:0]);
        end
        else
        begin
            unit_val = (quot > ecs_pkg::NUM_W'(32767)) ? 16'sh7FFF : quot[15:0];
        end
    end

    assign tbl_we    = norm_step && row_ok_reg;
    assign tbl_waddr = row_base_reg + ADDR_W'(j_reg);
    assign tbl_wdata = zn_reg ? '0 : unit_val;
    assign addr_a    = base_a_reg + ADDR_W'(qj_reg);
    assign addr_b    = base_b_reg + ADDR_W'(qj_reg);

    // Vector table: one write port (normalizer), two read ports (query).
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd_a_reg <= tbl_mem[addr_a];
        tbl_rd_b_reg <= tbl_mem[addr_b];
    end

    // Staging row: written by load transactions, read back while normalizing.
    always_ff @(posedge clk)
    begin
        if (accept && (func == ecs_pkg::FUNC_LOAD))
        begin
            stg_mem[cnt_reg[IDX_W-1:0]] <= element_value;
        end
        stg_rd_reg <= stg_mem[j_reg[IDX_W-1:0]];
    end

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dim_reg       <= ecs_pkg::DIM_RESET;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            miss_cnt_reg  <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            qj_reg        <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dim_reg <= cfg_wr_data;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_vld_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (func == ecs_pkg::FUNC_LOAD)
                        begin
                            if (load_cmpl)
                            begin
                                sum_reg   <= '0;
                                cnt_reg   <= '0;
                                n_reg     <= cnt_next;
                                j_reg     <= '0;
                                state_reg <= zn_now ? ST_NRD : ST_SQRT;
                            end
                            else
                            begin
                                sum_reg <= sum_next;
                                cnt_reg <= cnt_next;
                            end
                        end
                        else if (query_miss)
                        begin
                            if (miss_cnt_reg != '1)
                            begin
                                miss_cnt_reg <= miss_cnt_reg + 16'd1;
                            end
                            state_reg <= ST_POST;
                        end
                        else
                        begin
                            qj_reg    <= '0;
                            state_reg <= ST_QRUN;
                        end
                    end
                end
                ST_SQRT:
                begin
                    if (sqrt_stat.done)
                    begin
                        state_reg <= ST_NRD;
                    end
                end
                ST_NRD:
                begin
                    state_reg <= ST_NDIV;
                end
                ST_NDIV:
                begin
                    if (!zn_reg)
                    begin
                        state_reg <= ST_NWAIT;
                    end
                end
                ST_NWAIT:
                begin
                end
                ST_QRUN:
                begin
                    rd_vld_reg <= 1'b1;
                    qj_reg     <= qj_reg + CNT_W'(1);
                    if ((qj_reg + CNT_W'(1)) == dim_eff)
                    begin
                        state_reg <= ST_QDRAIN;
                    end
                end
                ST_QDRAIN:
                begin
                    if (acc_done)
                    begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST:
                begin
                    if (post_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Component stored: next one or row finished.
            if (norm_step)
            begin
                j_reg     <= j_reg + CNT_W'(1);
                state_reg <= last_comp ? ST_POST : ST_NRD;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept && (func == ecs_pkg::FUNC_LOAD) && load_cmpl)
        begin
            row_base_reg <= ADDR_W'(32'(word_index) * 32'(MAX_DIM));
            row_ok_reg   <= (32'(word_index) < 32'(VOCAB_DEPTH));
            zn_reg       <= zn_now;
            norm_reg     <= ecs_pkg::ROOT_W'(1);
        end
        if (sqrt_stat.done)
        begin
            norm_reg <= (root == '0) ? ecs_pkg::ROOT_W'(1) : root;
        end
        if (div_start)
        begin
            neg_reg <= stg_rd_reg[ecs_pkg::VAL_W-1];
        end
        if (accept && (func == ecs_pkg::FUNC_QUERY))
        begin
            base_a_reg       <= ADDR_W'(32'(first_word[ecs_pkg::ID_W-2:0]) * 32'(MAX_DIM));
            base_b_reg       <= ADDR_W'(32'(second_word[ecs_pkg::ID_W-2:0]) * 32'(MAX_DIM));
            post_score_reg   <= '0;
            post_missing_reg <= query_miss;
            post_zn_reg      <= 1'b0;
            post_ld_reg      <= 1'b0;
        end
        if (acc_done)
        begin
            post_score_reg <= ecs_pkg::sat_score(acc);
        end
        if (norm_step && last_comp)
        begin
            post_score_reg   <= '0;
            post_missing_reg <= 1'b0;
            post_zn_reg      <= zn_reg;
            post_ld_reg      <= 1'b1;
        end
        if ((state_reg == ST_POST) && post_free)
        begin
            score_reg    <= post_score_reg;
            missing_reg  <= post_missing_reg;
            zn_out_reg   <= post_zn_reg;
            ld_out_reg   <= post_ld_reg;
            miss_out_reg <= miss_cnt_reg;
        end
    end

    ecs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({sum_next, 16'b0}),
        .stat     (sqrt_stat),
        .root     (root)
    );

    ecs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_num),
        .denom (norm_reg),
        .stat  (div_stat),
        .quot  (quot)
    );

    ecs_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (mac_clear),
        .in_vld (rd_vld_reg),
        .a      (tbl_rd_a_reg),
        .b      (tbl_rd_b_reg),
        .busy   (mac_busy),
        .acc    (acc)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign score      = score_reg;
    assign missing    = missing_reg;
    assign zero_norm  = zn_out_reg;
    assign load_done  = ld_out_reg;
    assign miss_count = miss_out_reg;

endmodule

`default_nettype wire

### sv/ecs_sqrt.sv
// ----------------------------------------------------------------------------
// ecs_sqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ecs_pkg::RAD_W-1:0]   radicand,
    output      ecs_pkg::unit_stat_t         stat,
    output      logic [ecs_pkg::ROOT_W-1:0]  root
);

    logic [ecs_pkg::RAD_W-1:0] v_reg;
    logic [ecs_pkg::RAD_W-1:0] res_reg;
    logic [ecs_pkg::RAD_W-1:0] bit_reg;
    logic [4:0]                iter_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [ecs_pkg::RAD_W-1:0] trial;
    logic                      fits;

    assign trial = res_reg + bit_reg;
    assign fits  = (v_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 5'd1;
                if (iter_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = res_reg[ecs_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

### sv/ecs_div.sv
// ----------------------------------------------------------------------------
// ecs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ecs_pkg::NUM_W-1:0]   numer,
    input  wire logic [ecs_pkg::ROOT_W-1:0]  denom,
    output      ecs_pkg::unit_stat_t         stat,
    output      logic [ecs_pkg::NUM_W-1:0]   quot
);

    logic [ecs_pkg::ROOT_W-1:0] rem_reg;
    logic [ecs_pkg::ROOT_W-1:0] den_reg;
    logic [ecs_pkg::NUM_W-1:0]  num_reg;
    logic [ecs_pkg::NUM_W-1:0]  q_reg;
    logic [5:0]                 iter_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [ecs_pkg::ROOT_W:0]   shifted;
    logic [ecs_pkg::ROOT_W:0]   diff;
    logic                       fits;

    assign shifted = {rem_reg, num_reg[ecs_pkg::NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 6'd1;
                if (iter_reg == 6'(ecs_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= denom;
            num_reg <= numer;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[ecs_pkg::ROOT_W-1:0] : shifted[ecs_pkg::ROOT_W-1:0];
            num_reg <= {num_reg[ecs_pkg::NUM_W-2:0], 1'b0};
            q_reg   <= {q_reg[ecs_pkg::NUM_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

`default_nettype wire

### sv/ecs_mac.sv
// ----------------------------------------------------------------------------
// ecs_mac
// Multiply-accumulate: registered 16x16 product, then 48-bit accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_mac (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               clear,
    input  wire logic                               in_vld,
    input  wire logic signed [ecs_pkg::VAL_W-1:0]   a,
    input  wire logic signed [ecs_pkg::VAL_W-1:0]   b,
    output      logic                               busy,
    output      logic signed [ecs_pkg::ACC_W-1:0]   acc
);

    logic signed [2*ecs_pkg::VAL_W-1:0] prod_reg;
    logic                               prod_vld_reg;
    logic signed [ecs_pkg::ACC_W-1:0]   acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ecs_pkg::ACC_W'(prod_reg);
        end
    end

    assign busy = prod_vld_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

### sv/ecs_checker.sv
// ----------------------------------------------------------------------------
// ecs_checker
// Port-level checks of the embedding cosine similarity unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ecs_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               func,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic signed [ecs_pkg::SCORE_W-1:0] score,
    input wire logic                               missing,
    input wire logic                               zero_norm,
    input wire logic                               load_done,
    input wire logic [ecs_pkg::MISS_W-1:0]         miss_count
);

    // A stalled result transaction holds.
    `ECS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(score) && $stable(miss_count), "stalled result changed")

    // Load results never report a miss.
    `ECS_ASSERT_IMP(a_ld_no_miss, out_valid && load_done, !missing, "load result flagged missing")

    // Zero norm only on load results.
    `ECS_ASSERT_IMP(a_zn_on_load, out_valid && zero_norm, load_done, "zero_norm on query result")

    // A miss scores zero and the counter has moved.
    `ECS_ASSERT_IMP(a_miss_zero, out_valid && missing, (score == 0) && (miss_count != 0), "bad miss result")

    // A query keeps the block busy the next cycle.
    `ECS_ASSERT_NXT(a_query_busy, in_valid && !in_stall && func, in_stall, "query not held busy")

endmodule

bind embedding_cosine_similarity_unit ecs_checker u_ecs_checker (.*);

`default_nettype wire

### bench/similarity_scoreboard.sv
// ----------------------------------------------------------------------------
// similarity_scoreboard
// Watches both channels and the config port of the similarity unit, predicts
// every result from its own copy of the table and counters, and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module similarity_scoreboard #(
    parameter int VOCAB = ecs_pkg::VOCAB_DEPTH_DEF,
    parameter int MAXD  = ecs_pkg::MAX_DIM_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ecs_pkg::CFG_W-1:0]           cfg_wr_data,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic                                func,
    input  wire logic [ecs_pkg::ROW_W-1:0]           word_index,
    input  wire logic signed [ecs_pkg::VAL_W-1:0]    element_value,
    input  wire logic signed [ecs_pkg::ID_W-1:0]     first_word,
    input  wire logic signed [ecs_pkg::ID_W-1:0]     second_word,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic signed [ecs_pkg::SCORE_W-1:0]  score,
    input  wire logic                                missing,
    input  wire logic                                zero_norm,
    input  wire logic                                load_done,
    input  wire logic [ecs_pkg::MISS_W-1:0]          miss_count,
    output int                                       errors,
    output int                                       outstanding
);

    typedef struct packed {
        logic signed [ecs_pkg::SCORE_W-1:0] score;
        logic                               missing;
        logic                               zero_norm;
        logic                               load_done;
        logic [ecs_pkg::MISS_W-1:0]         miss_count;
    } sim_result_t;

    shortint                    unit_rows [int];      // row*MAXD+pos -> Q1.15 component
    shortint                    raw_stage [MAXD];
    logic [ecs_pkg::SUM_W-1:0]  sq_sum;
    int                         staged;
    logic [ecs_pkg::MISS_W-1:0] misses;
    logic [ecs_pkg::CFG_W-1:0]  dim_reg;
    sim_result_t                pending_results [$];

    function automatic int active_dim();
        if (dim_reg == 0) return 1;
        if (int'(dim_reg) > MAXD) return MAXD;
        return int'(dim_reg);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Round-to-nearest (ties away) divide by the norm, saturated to Q1.15.
    function automatic shortint unit_value(input shortint x, input longint unsigned n);
        longint unsigned mag;
        longint unsigned q;
        mag = (x < 0) ? longint'(-int'(x)) : longint'(x);
        q = ((mag << 23) + (n >> 1)) / n;
        if (x < 0) return (q > 32768) ? -16'sd32768 : shortint'(-longint'(q));
        return (q > 32767) ? 16'sd32767 : shortint'(q);
    endfunction

    function automatic shortint table_at(input int key);
        if (unit_rows.exists(key)) return unit_rows[key];
        return 0;
    endfunction

    // Loads return 1 only on row completion; queries always return 1.
    function automatic bit predict_item(output sim_result_t res);
        int               n;
        longint unsigned  root;
        longint           acc;
        int               a;
        int               b;
        bit               zn;
        res = '0;
        if (func == ecs_pkg::FUNC_LOAD)
        begin
            if (staged >= MAXD) staged = MAXD - 1;
            raw_stage[staged] = element_value;
            sq_sum = sq_sum + ecs_pkg::SUM_W'(longint'(element_value) * longint'(element_value));
            staged++;
            if (staged < active_dim()) return 0;
            n = staged;
            zn = (sq_sum == 0);
            root = zn ? 1 : int_sqrt(64'(sq_sum) << 16);
            if (root == 0) root = 1;
            if (int'(word_index) < VOCAB)
                for (int j = 0; j < n; j++)
                    unit_rows[int'(word_index) * MAXD + j] =
                        zn ? 16'sd0 : unit_value(raw_stage[j], root);
            sq_sum = '0;
            staged = 0;
            res.zero_norm = zn;
            res.load_done = 1'b1;
            res.miss_count = misses;
            return 1;
        end
        a = first_word;
        b = second_word;
        if (a < 0 || b < 0 || a >= VOCAB || b >= VOCAB)
        begin
            if (misses != 16'hFFFF) misses++;
            res.missing = 1'b1;
            res.miss_count = misses;
            return 1;
        end
        acc = 0;
        for (int j = 0; j < active_dim(); j++)
            acc += longint'(table_at(a * MAXD + j)) * longint'(table_at(b * MAXD + j));
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        res.score = acc[ecs_pkg::SCORE_W-1:0];
        res.miss_count = misses;
        return 1;
    endfunction

    // Output side first, then the input transaction, then a config write,
    // matching the order in which the block sees the same clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        sim_result_t want;
        sim_result_t got;
        if (!rst_n)
        begin
            sq_sum = '0;
            staged = 0;
            misses = '0;
            dim_reg = ecs_pkg::DIM_RESET;
            errors = 0;
            pending_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{score, missing, zero_norm, load_done, miss_count};
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, got %p", $time, got);
                    errors = errors + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result differs, expected %p actual %p",
                                 $time, want, got);
                        errors = errors + 1;
                    end
                end
            end
            if (in_valid && !in_stall && predict_item(want))
                pending_results.push_back(want);
            if (cfg_wr_en) dim_reg = cfg_wr_data;
            outstanding = pending_results.size();
        end
    end

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives row loads and word-pair queries into the similarity unit under
// random gaps and output stalls; a scoreboard module predicts and checks.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int ROWS = ecs_pkg::VOCAB_DEPTH_DEF;
    localparam int MAXD = ecs_pkg::MAX_DIM_DEF;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_wr_en;
    logic [ecs_pkg::CFG_W-1:0]          cfg_wr_data;
    logic                               in_valid;
    logic                               in_stall;
    logic                               func;
    logic [ecs_pkg::ROW_W-1:0]          word_index;
    logic signed [ecs_pkg::VAL_W-1:0]   element_value;
    logic signed [ecs_pkg::ID_W-1:0]    first_word;
    logic signed [ecs_pkg::ID_W-1:0]    second_word;
    logic                               out_valid;
    logic                               out_stall;
    logic signed [ecs_pkg::SCORE_W-1:0] score;
    logic                               missing;
    logic                               zero_norm;
    logic                               load_done;
    logic [ecs_pkg::MISS_W-1:0]         miss_count;
    int                                 errors;
    int                                 outstanding;

    // Stimulus-side bookkeeping: how many positions of each row hold data,
    // so a query never reads a component that was never written.
    int  row_len [ROWS];
    int  loaded_rows [$];
    int  dim_now;          // effective dimension
    int  staged_now;       // components of the row being loaded
    bit  quiet;            // no idling on either side
    bit  hold_req;         // ask the receiver for one long hold-off

    embedding_cosine_similarity_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .word_index(word_index), .element_value(element_value),
        .first_word(first_word), .second_word(second_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .score(score), .missing(missing), .zero_norm(zero_norm),
        .load_done(load_done), .miss_count(miss_count)
    );

    similarity_scoreboard scoreboard (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .word_index(word_index), .element_value(element_value),
        .first_word(first_word), .second_word(second_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .score(score), .missing(missing), .zero_norm(zero_norm),
        .load_done(load_done), .miss_count(miss_count),
        .errors(errors), .outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: short random stall bursts, a few long ones, and one
    // requested hold-off long enough to back the block up into its input.
    initial
    begin
        int stall_left;
        int r;
        out_stall = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 8) stall_left = $urandom_range(1, 3);
                else if (r < 10) stall_left = $urandom_range(10, 60);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic int gap_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One transaction on the input channel. Acceptance is judged from the
    // stall seen at the falling edge, which holds until the next rising edge.
    task automatic send_item(input logic f, input logic [ecs_pkg::ROW_W-1:0] row,
                             input logic signed [ecs_pkg::VAL_W-1:0] val,
                             input logic signed [ecs_pkg::ID_W-1:0] a,
                             input logic signed [ecs_pkg::ID_W-1:0] b);
        int gap;
        in_valid      <= 1'b1;
        func          <= f;
        word_index    <= row;
        element_value <= val;
        first_word    <= a;
        second_word   <= b;
        forever
        begin
            @(negedge clk);
            if (!in_stall) break;
        end
        @(posedge clk);
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_load(input int row, input logic signed [ecs_pkg::VAL_W-1:0] val);
        send_item(ecs_pkg::FUNC_LOAD, ecs_pkg::ROW_W'(row), val,
                  ecs_pkg::ID_W'($urandom), ecs_pkg::ID_W'($urandom));
        staged_now++;
        if (staged_now >= dim_now)
        begin
            if (row_len[row] == 0) loaded_rows.push_back(row);
            if (staged_now > row_len[row]) row_len[row] = staged_now;
            staged_now = 0;
        end
    endtask

    task automatic send_query(input int a, input int b);
        send_item(ecs_pkg::FUNC_QUERY, ecs_pkg::ROW_W'($urandom), ecs_pkg::VAL_W'($urandom),
                  ecs_pkg::ID_W'(a), ecs_pkg::ID_W'(b));
    endtask

    // Component value by row flavor: 0 random, 1 zero row, 2 full-scale.
    function automatic logic signed [ecs_pkg::VAL_W-1:0] pick_value(input int flavor);
        if (flavor == 1) return '0;
        if (flavor == 2) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return ecs_pkg::VAL_W'($urandom);
    endfunction

    // Finish the row in progress, or load a whole fresh one.
    task automatic load_row(input int row, input int flavor);
        while (1)
        begin
            send_load(row, pick_value(flavor));
            if (staged_now == 0) break;
        end
    endtask

    function automatic int valid_word();
        int pool [$];
        foreach (loaded_rows[i])
            if (row_len[loaded_rows[i]] >= dim_now) pool.push_back(loaded_rows[i]);
        if (pool.size() == 0) return -1;
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    function automatic int bad_word();
        if ($urandom_range(0, 1)) return -1;
        return -int'($urandom_range(2, 4096));
    endfunction

    // Wait for every expected result, then cover non-result load items.
    // The count is read at the falling edge, after the scoreboard updated it.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_dim(input int value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ecs_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        if (value == 0) dim_now = 1;
        else if (value > MAXD) dim_now = MAXD;
        else dim_now = value;
        @(posedge clk);
    endtask

    initial
    begin
        int a;
        int b;
        int row;
        int flavor;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        func = ecs_pkg::FUNC_LOAD;
        word_index = '0;
        element_value = '0;
        first_word = '0;
        second_word = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        staged_now = 0;
        dim_now = 300;
        foreach (row_len[i]) row_len[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-component rows: full scale, opposite sign, zero norm.
        write_dim(1);
        send_load(0, 16'sh7FFF);
        send_load(4095, 16'sh8000);
        send_load(2048, 16'sh0000);
        send_query(0, 0);
        send_query(0, 4095);
        send_query(4095, 4095);
        send_query(2048, 0);
        send_query(-1, 0);
        send_query(0, -1);
        send_query(-4096, 4095);
        drain();

        // Dimension lowered while a row is half loaded: the next component
        // completes the row with everything staged so far.
        write_dim(4);
        send_load(6, 16'sh1000);
        send_load(6, -16'sh2000);
        send_load(6, 16'sh0FFF);
        drain();
        write_dim(2);
        send_load(6, 16'sh0001);
        load_row(5, 0);
        send_query(6, 6);
        send_query(5, 6);
        drain();

        // Widest row; an over-range setting acts as the maximum.
        write_dim(512);
        load_row(8, 2);
        drain();
        write_dim(1023);
        send_query(8, 8);
        drain();
        write_dim(0);
        send_query(8, 0);
        drain();

        // Random phases at small dimensions; rows are mostly well formed,
        // with queries mixed in, some of them during a load.
        for (int phase = 0; phase < 4; phase++)
        begin
            write_dim(phase == 0 ? 3 : (phase == 1 ? 1 : (phase == 2 ? 7 : 5)));
            quiet = (phase == 2);
            row = $urandom_range(0, 3) == 0 ? $urandom_range(0, ROWS - 1)
                                            : $urandom_range(0, 15);
            flavor = $urandom_range(0, 9) == 0 ? 1 : ($urandom_range(0, 9) == 0 ? 2 : 0);
            for (int k = 0; k < 45; k++)
            begin
                if ($urandom_range(0, 99) < 55)
                begin
                    send_load(row, pick_value(flavor));
                    if (staged_now == 0)
                    begin
                        row = $urandom_range(0, 3) == 0 ? $urandom_range(0, ROWS - 1)
                                                        : $urandom_range(0, 15);
                        flavor = $urandom_range(0, 9) == 0 ? 1
                               : ($urandom_range(0, 9) == 0 ? 2 : 0);
                    end
                end
                else
                begin
                    a = valid_word();
                    b = valid_word();
                    if (a < 0 || $urandom_range(0, 99) < 15) a = bad_word();
                    if (b < 0 || $urandom_range(0, 99) < 15) b = bad_word();
                    send_query(a, b);
                end
                if (phase == 1 && k == 20)
                begin
                    // Receiver holds off while misses keep coming.
                    hold_req = 1'b1;
                    for (int m = 0; m < 12; m++) send_query(-1, bad_word());
                end
                if (phase == 3 && k == 20) drain();
            end
            if (staged_now != 0) load_row(row, flavor);
            drain();
        end

        send_query(bad_word(), valid_word());
        send_query(valid_word(), valid_word());
        drain();
        repeat (60) @(posedge clk);

        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
